@@ hdl/ncsm_pkg.sv @@
// shared types and constants for the natural cubic spline moments unit
package ncsm_pkg;

	localparam int XW    = 16;
	localparam int FW    = 32;
	localparam int SW    = 48;
	localparam int QW    = 63;
	localparam int CNT_W = 7;

	localparam logic [QW-1:0] QCAP = {1'b1, {(QW-1){1'b0}}};

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_DROP  = 2'd2;

	typedef struct packed {
		logic [XW-1:0]        x_coord;
		logic signed [FW-1:0] f_value;
		logic                 last_point;
	} knot_t;

	typedef struct packed {
		logic signed [FW-1:0] second_deriv;
		logic                 last_result;
		logic [1:0]           status;
	} moment_t;

	typedef struct packed {
		logic             go;
		logic [QW-1:0]    dividend;
		logic [SW-1:0]    divisor;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] quo;
	} div_rsp_t;

endpackage

@@ hdl/ncsm_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle, quotient capped at 2^62
module ncsm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ncsm_pkg::div_req_t  req,
	output ncsm_pkg::div_rsp_t  rsp
);
	import ncsm_pkg::*;

	logic [QW-1:0]    num_q;
	logic [SW-1:0]    rem_q;
	logic [SW-1:0]    d_q;
	logic [QW-2:0]    q_q;
	logic             sat_q;
	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [SW:0]      remx;
	logic [SW:0]      rem_diff;
	logic             ge;
	logic [QW-1:0]    q_sh;

	always_comb begin
		remx     = {rem_q, num_q[QW-1]};
		rem_diff = remx - {1'b0, d_q};
		ge       = remx >= {1'b0, d_q};
		q_sh     = {q_q, ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= req.dividend;
			rem_q <= '0;
			d_q   <= req.divisor;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (run_q) begin
			num_q <= {num_q[QW-2:0], 1'b0};
			rem_q <= ge ? rem_diff[SW-1:0] : remx[SW-1:0];
			// once the quotient reaches the cap it stays there
			if (!sat_q) begin
				if (q_sh[QW-1]) begin
					sat_q <= 1'b1;
				end else begin
					q_q <= q_sh[QW-2:0];
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sat_q ? QCAP : {1'b0, q_q};

`ifndef SYNTHESIS
	a_no_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		!(run_q && cnt_q == '0))
		else $error("divider running with zero step count");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q)
		else $error("divider done while still running");
`endif

endmodule

@@ hdl/natural_cubic_spline_moments_unit.sv @@
// natural cubic spline moments unit: knot store, tridiagonal sweeps, moment output
//
// Knots come in on knot when start is high and busy is low, one per cycle, in
// ascending x order. A knot with last_point set closes the set: busy rises and
// the block solves for the second derivatives on one shared serial divider and
// one 16x48 multiplier. The forward sweep runs slope, pivot and right-hand side
// divisions on the divider, the backward sweep one division per row.
// Then one result per knot comes out on result, each marked by valid for one
// cycle, in knot order; last_result marks the final knot.
// All results carry the set's status. Sets of fewer than three knots or with
// non-increasing x give all-zero moments. Knots past MAX_POINTS are dropped.
// The receiver cannot stall; results are presented once. After the last result
// busy falls and a new set may start. Reset empties the knot set and idles.
module natural_cubic_spline_moments_unit #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ncsm_pkg::knot_t   knot,
	output logic              valid,
	output ncsm_pkg::moment_t result
);
	import ncsm_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0]    MAXC     = CW'(MAX_POINTS);
	localparam logic [CNT_W-1:0] STEPS_0  = CNT_W'(QW);
	localparam logic [CNT_W-1:0] STEPS_F  = CNT_W'(QW + FRAC_BITS);
	localparam logic [CNT_W-1:0] STEPS_2F = CNT_W'(QW + 2 * FRAC_BITS);
	localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] S48_MIN = -64'sh0000_8000_0000_0000;

	typedef enum logic [23:0] {
		S_IDLE  = 24'h000001,
		S_CHK   = 24'h000002,
		S_IWAIT = 24'h000004,
		S_IDATA = 24'h000008,
		S_FADDR = 24'h000010,
		S_FWAIT = 24'h000020,
		S_FDATA = 24'h000040,
		S_FSDIV = 24'h000080,
		S_FROW  = 24'h000100,
		S_RTMUL = 24'h000200,
		S_RTGO  = 24'h000400,
		S_RTDIV = 24'h000800,
		S_RWMUL = 24'h001000,
		S_RWGO  = 24'h002000,
		S_RWDIV = 24'h004000,
		S_BADDR = 24'h008000,
		S_BWAIT = 24'h010000,
		S_BDATA = 24'h020000,
		S_BMUL  = 24'h040000,
		S_BGO   = 24'h080000,
		S_BDIV  = 24'h100000,
		S_EADDR = 24'h200000,
		S_EWAIT = 24'h400000,
		S_EOUT  = 24'h800000
	} state_t;

	function automatic logic signed [SW-1:0] sat48(input logic signed [63:0] v);
		if (v > S48_MAX) return S48_MAX[SW-1:0];
		if (v < S48_MIN) return S48_MIN[SW-1:0];
		return v[SW-1:0];
	endfunction

	function automatic logic [SW-1:0] mag48(input logic signed [SW-1:0] v);
		return v[SW-1] ? SW'(-v) : SW'(v);
	endfunction

	function automatic logic [QW-1:0] cap62(input logic [63:0] p);
		return (p > 64'(QCAP)) ? QCAP : p[QW-1:0];
	endfunction

	function automatic logic signed [FW-1:0] sat32(input logic signed [SW-1:0] v);
		if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -48'sh0000_8000_0000) return -32'sh8000_0000;
		return v[FW-1:0];
	endfunction

	// stores
	logic [XW-1:0]        x_mem [MAX_POINTS];
	logic signed [FW-1:0] f_mem [MAX_POINTS];
	logic signed [SW-1:0] u_mem [MAX_POINTS];
	logic signed [SW-1:0] v_mem [MAX_POINTS];
	logic signed [SW-1:0] m_mem [MAX_POINTS];

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [1:0]           err_q;
	logic [AW-1:0]        k_q;
	logic                 zero_q;
	logic                 valid_q;
	moment_t              result_q;

	logic [AW-1:0]        ra_q;
	logic [AW-1:0]        rb_q;
	logic [XW-1:0]        x_rd_q;
	logic signed [FW-1:0] f_rd_q;
	logic signed [SW-1:0] u_rd_q;
	logic signed [SW-1:0] v_rd_q;
	logic signed [SW-1:0] m_rd_q;

	logic [XW-1:0]        xlast_q;
	logic [XW-1:0]        xa_q;
	logic signed [FW-1:0] fa_q;
	logic [XW-1:0]        hp_q;
	logic [XW-1:0]        hn_q;
	logic signed [36:0]   sp_q;
	logic signed [36:0]   sn_q;
	logic                 sneg_q;
	logic                 nneg_q;
	logic signed [SW-1:0] uprev_q;
	logic signed [SW-1:0] vprev_q;
	logic signed [SW-1:0] mnext_q;
	logic [QW-1:0]        t_q;
	logic [63:0]          prod_q;

	div_req_t             div_req;
	div_rsp_t             div_rsp;

	logic                 ld_we;
	logic                 uv_we;
	logic                 m_we;
	logic                 last_row;
	logic                 last_emit;
	logic [XW-1:0]        hn_new;
	logic signed [35:0]   diff36;
	logic signed [35:0]   d6;
	logic [35:0]          d6_mag;
	logic signed [36:0]   quo37;
	logic signed [36:0]   sn_new;
	logic [63:0]          diag;
	logic signed [SW-1:0] u0;
	logic signed [SW-1:0] v0;
	logic signed [63:0]   qv;
	logic signed [SW-1:0] u_row;
	logic signed [SW-1:0] v_row;
	logic signed [63:0]   hm;
	logic signed [63:0]   num;
	logic [QW-1:0]        num_mag;
	logic signed [63:0]   mq;
	logic signed [SW-1:0] m_new;
	logic [XW-1:0]        mul_a;
	logic [SW-1:0]        mul_b;
	logic [63:0]          mul_p;
	logic [1:0]           status;

	ncsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		last_row  = (CW'(k_q) + CW'(2)) == count_q;
		last_emit = (CW'(k_q) + CW'(1)) == count_q;
		ld_we     = (state_q == S_IDLE) && start && (count_q < MAXC);

		// slope of the gap just fetched
		hn_new = x_rd_q - xa_q;
		diff36 = {{4{f_rd_q[FW-1]}}, f_rd_q} - {{4{fa_q[FW-1]}}, fa_q};
		d6     = (diff36 <<< 2) + (diff36 <<< 1);
		d6_mag = d6[35] ? 36'(-d6) : 36'(d6);
		quo37  = {2'b00, div_rsp.quo[34:0]};
		sn_new = sneg_q ? -quo37 : quo37;

		// forward elimination row
		diag  = 64'({1'b0, hp_q} + {1'b0, hn_q}) << (FRAC_BITS + 1);
		u0    = diag[SW-1:0];
		v0    = sat48(64'(sn_q) - 64'(sp_q));
		qv    = vprev_q[SW-1] ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
		u_row = sat48($signed(diag) - $signed({1'b0, t_q}));
		v_row = sat48(64'(sn_q) - 64'(sp_q) - qv);

		// back substitution row
		hm      = mnext_q[SW-1] ? -$signed({1'b0, cap62(prod_q)})
		                        : $signed({1'b0, cap62(prod_q)});
		num     = 64'(v_rd_q) - hm;
		num_mag = num[63] ? QW'(-num) : QW'(num);
		mq      = nneg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
		m_new   = sat48(mq);

		uv_we = ((state_q == S_FROW) && (k_q == AW'(1)))
		     || ((state_q == S_RWDIV) && div_rsp.done);
		m_we  = (state_q == S_BDIV) && div_rsp.done;

		priority if (err_q[0]) status = ST_ORDER;
		else if (err_q[1])     status = ST_DROP;
		else                   status = ST_OK;
	end

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			S_RTMUL: begin
				mul_a = hp_q;
				mul_b = SW'(hp_q);
			end
			S_RWMUL: begin
				mul_a = hp_q;
				mul_b = mag48(vprev_q);
			end
			default: begin
				mul_a = hn_q;
				mul_b = mag48(mnext_q);
			end
		endcase
		mul_p = 64'(mul_a) * 64'(mul_b);
	end

	// shared divider requests
	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_FDATA: begin
				div_req.go       = 1'b1;
				div_req.dividend = QW'(d6_mag);
				div_req.divisor  = SW'(hn_new);
				div_req.steps    = STEPS_0;
			end
			S_RTGO: begin
				div_req.go       = 1'b1;
				div_req.dividend = prod_q[QW-1:0];
				div_req.divisor  = uprev_q;
				div_req.steps    = STEPS_2F;
			end
			S_RWGO: begin
				div_req.go       = 1'b1;
				div_req.dividend = cap62(prod_q);
				div_req.divisor  = uprev_q;
				div_req.steps    = STEPS_F;
			end
			S_BGO: begin
				div_req.go       = 1'b1;
				div_req.dividend = num_mag;
				div_req.divisor  = u_rd_q;
				div_req.steps    = STEPS_F;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			err_q   <= '0;
			k_q     <= '0;
			zero_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (count_q < MAXC) begin
							if (count_q != '0 && knot.x_coord <= xlast_q) err_q[0] <= 1'b1;
							count_q <= count_q + CW'(1);
						end else begin
							err_q[1] <= 1'b1;
						end
						if (knot.last_point) state_q <= S_CHK;
					end
				end
				S_CHK: begin
					k_q <= '0;
					if (count_q < CW'(3) || err_q[0]) begin
						zero_q  <= 1'b1;
						state_q <= S_EADDR;
					end else begin
						zero_q  <= 1'b0;
						state_q <= S_IWAIT;
					end
				end
				S_IWAIT: state_q <= S_IDATA;
				S_IDATA: state_q <= S_FADDR;
				S_FADDR: state_q <= S_FWAIT;
				S_FWAIT: state_q <= S_FDATA;
				S_FDATA: state_q <= S_FSDIV;
				S_FSDIV: if (div_rsp.done) state_q <= S_FROW;
				S_FROW: begin
					if (k_q == '0) begin
						k_q     <= k_q + AW'(1);
						state_q <= S_FADDR;
					end else if (k_q == AW'(1)) begin
						if (last_row) begin
							state_q <= S_BADDR;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_FADDR;
						end
					end else begin
						state_q <= S_RTMUL;
					end
				end
				S_RTMUL: state_q <= S_RTGO;
				S_RTGO:  state_q <= S_RTDIV;
				S_RTDIV: if (div_rsp.done) state_q <= S_RWMUL;
				S_RWMUL: state_q <= S_RWGO;
				S_RWGO:  state_q <= S_RWDIV;
				S_RWDIV: begin
					if (div_rsp.done) begin
						if (last_row) begin
							state_q <= S_BADDR;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_FADDR;
						end
					end
				end
				S_BADDR: state_q <= S_BWAIT;
				S_BWAIT: state_q <= S_BDATA;
				S_BDATA: state_q <= S_BMUL;
				S_BMUL:  state_q <= S_BGO;
				S_BGO:   state_q <= S_BDIV;
				S_BDIV: begin
					if (div_rsp.done) begin
						if (k_q == AW'(1)) begin
							k_q     <= '0;
							state_q <= S_EADDR;
						end else begin
							k_q     <= k_q - AW'(1);
							state_q <= S_BADDR;
						end
					end
				end
				S_EADDR: state_q <= S_EWAIT;
				S_EWAIT: state_q <= S_EOUT;
				S_EOUT: begin
					valid_q <= 1'b1;
					if (last_emit) begin
						count_q <= '0;
						err_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= S_EADDR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (ld_we) xlast_q <= knot.x_coord;
			end
			S_CHK: ra_q <= '0;
			S_IDATA: begin
				xa_q <= x_rd_q;
				fa_q <= f_rd_q;
			end
			S_FADDR: ra_q <= k_q + AW'(1);
			S_FDATA: begin
				hn_q   <= hn_new;
				xa_q   <= x_rd_q;
				fa_q   <= f_rd_q;
				sneg_q <= d6[35];
			end
			S_FSDIV: begin
				if (div_rsp.done) sn_q <= sn_new;
			end
			S_FROW: begin
				if (k_q == '0) begin
					sp_q <= sn_q;
					hp_q <= hn_q;
				end else if (k_q == AW'(1)) begin
					uprev_q <= u0;
					vprev_q <= v0;
					sp_q    <= sn_q;
					hp_q    <= hn_q;
					mnext_q <= '0;
				end
			end
			S_RTMUL: prod_q <= mul_p;
			S_RTDIV: begin
				if (div_rsp.done) t_q <= div_rsp.quo;
			end
			S_RWMUL: prod_q <= mul_p;
			S_RWDIV: begin
				if (div_rsp.done) begin
					uprev_q <= u_row;
					vprev_q <= v_row;
					sp_q    <= sn_q;
					hp_q    <= hn_q;
					mnext_q <= '0;
				end
			end
			S_BADDR: begin
				ra_q <= k_q;
				rb_q <= k_q - AW'(1);
			end
			S_BDATA: begin
				hn_q <= xa_q - x_rd_q;
				xa_q <= x_rd_q;
			end
			S_BMUL: prod_q <= mul_p;
			S_BGO:  nneg_q <= num[63];
			S_BDIV: begin
				if (div_rsp.done) mnext_q <= m_new;
			end
			S_EADDR: rb_q <= k_q;
			S_EOUT: begin
				// end moments and degenerate sets read as zero
				if (zero_q || k_q == '0 || last_emit) begin
					result_q.second_deriv <= '0;
				end else begin
					result_q.second_deriv <= sat32(m_rd_q);
				end
				result_q.last_result <= last_emit;
				result_q.status      <= status;
			end
			default: begin
				xa_q <= xa_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			x_mem[count_q[AW-1:0]] <= knot.x_coord;
			f_mem[count_q[AW-1:0]] <= knot.f_value;
		end
		x_rd_q <= x_mem[ra_q];
		f_rd_q <= f_mem[ra_q];
	end

	always_ff @(posedge clk) begin
		if (uv_we) begin
			u_mem[k_q - AW'(1)] <= (state_q == S_FROW) ? u0 : u_row;
			v_mem[k_q - AW'(1)] <= (state_q == S_FROW) ? v0 : v_row;
		end
		u_rd_q <= u_mem[rb_q];
		v_rd_q <= v_mem[rb_q];
	end

	always_ff @(posedge clk) begin
		if (m_we) m_mem[k_q] <= m_new;
		m_rd_q <= m_mem[rb_q];
	end

	assign busy   = state_q != S_IDLE;
	assign valid  = valid_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXC)
		else $error("knot count beyond capacity");
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && knot.last_point) |=> busy)
		else $error("closing knot did not start the solve");
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && result.last_result) |-> (!busy && count_q == '0))
		else $error("final result without return to idle");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.go |=> !div_rsp.done)
		else $error("divider finished right after a request");
`endif

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the natural cubic spline moments unit
module tb;
	import ncsm_pkg::*;

	localparam int MAXP = 64;
	localparam int FRAC = 16;

	class spline_scoreboard;
		localparam bit [63:0] CAP = 64'h4000_0000_0000_0000;
		localparam longint S48HI = 64'sh0000_7FFF_FFFF_FFFF;
		localparam longint S48LO = -64'sh0000_7FFF_FFFF_FFFF - 1;

		bit [15:0] xs[MAXP];
		longint    fs[MAXP];
		longint    piv[MAXP];
		longint    rhs[MAXP];
		longint    mom[MAXP];
		int        count;
		bit [1:0]  flags;
		moment_t   moments_due[$];
		int        mismatches;

		function new();
			count = 0;
			flags = 0;
			mismatches = 0;
		endfunction

		function longint sat48(longint v);
			if (v > S48HI) return S48HI;
			if (v < S48LO) return S48LO;
			return v;
		endfunction

		// bit-serial a * 2^s / d, saturating at 2^62
		function bit [63:0] div_shift(bit [63:0] a, int s, bit [63:0] d);
			bit [63:0] rem;
			bit [63:0] q;
			bit        b;
			rem = 0;
			q = 0;
			for (int k = 0; k < 64 + s; k++) begin
				b = (k < 64) ? a[63-k] : 1'b0;
				if (q >= CAP) return CAP;
				rem = {rem[62:0], b};
				q = q << 1;
				if (rem >= d) begin
					rem = rem - d;
					q[0] = 1'b1;
				end
			end
			return (q > CAP) ? CAP : q;
		endfunction

		function bit [63:0] mag(longint v);
			return (v < 0) ? 64'(-v) : 64'(v);
		endfunction

		function longint sdiv(longint num, int s, bit [63:0] d);
			bit [63:0] q;
			q = div_shift(mag(num), s, d);
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		function longint hmul(bit [63:0] h, longint v);
			bit [63:0] m;
			bit [63:0] p;
			m = mag(v);
			p = (h != 0 && m > CAP / h) ? CAP : h * m;
			if (p > CAP) p = CAP;
			return (v < 0) ? -longint'(p) : longint'(p);
		endfunction

		function bit [63:0] gap(int i);
			return 64'(xs[i+1]) - 64'(xs[i]);
		endfunction

		function longint slope(int i);
			return sdiv(6 * (fs[i+1] - fs[i]), 0, gap(i));
		endfunction

		function void solve_moments(int n);
			int        g;
			bit [63:0] h;
			bit [63:0] hn;
			bit [63:0] up;
			longint    diag;
			longint    t;
			longint    w;
			longint    num;
			g = n - 1;
			for (int i = 0; i < n; i++) mom[i] = 0;
			if (n < 3 || flags[0]) return;
			piv[0] = longint'((2 * (gap(0) + gap(1))) << FRAC);
			rhs[0] = sat48(slope(1) - slope(0));
			for (int i = 1; i + 2 <= g; i++) begin
				h = gap(i);
				hn = gap(i + 1);
				up = 64'(piv[i-1]);
				diag = longint'((2 * (h + hn)) << FRAC);
				t = longint'(div_shift(h * h, 2 * FRAC, up));
				w = hmul(h, rhs[i-1]);
				piv[i] = sat48(diag - t);
				rhs[i] = sat48(slope(i + 1) - slope(i) - sdiv(w, FRAC, up));
			end
			for (int i = g - 1; i >= 1; i--) begin
				num = rhs[i-1] - hmul(gap(i), mom[i+1]);
				mom[i] = sat48(sdiv(num, FRAC, 64'(piv[i-1])));
			end
		endfunction

		function void note_knot(knot_t k);
			moment_t m;
			longint  v;
			if (count < MAXP) begin
				if (count > 0 && k.x_coord <= xs[count-1]) flags[0] = 1'b1;
				xs[count] = k.x_coord;
				fs[count] = longint'(k.f_value);
				count++;
			end else begin
				flags[1] = 1'b1;
			end
			if (!k.last_point) return;
			solve_moments(count);
			for (int i = 0; i < count; i++) begin
				v = mom[i];
				if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
				if (v < -64'sh8000_0000) v = -64'sh8000_0000;
				m.second_deriv = v[31:0];
				m.last_result = (i + 1 == count);
				m.status = flags[0] ? ST_ORDER : (flags[1] ? ST_DROP : ST_OK);
				moments_due.insert(moments_due.size(), m);
			end
			count = 0;
			flags = 0;
		endfunction

		function void check_moment(moment_t got);
			moment_t want;
			if (moments_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected moment: deriv %0d last %0b status %0d",
						got.second_deriv, got.last_result, got.status);
				return;
			end
			want = moments_due.pop_front();
			if (got.second_deriv !== want.second_deriv ||
			    got.last_result !== want.last_result || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("moment mismatch: deriv %0d/%0d last %0b/%0b status %0d/%0d",
						want.second_deriv, got.second_deriv, want.last_result,
						got.last_result, want.status, got.status);
			end
		endfunction

		function int pending();
			return moments_due.size();
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	knot_t   knot;
	logic    valid;
	moment_t result;

	spline_scoreboard sb;
	int idle_pct;
	int knots_sent;

	natural_cubic_spline_moments_unit #(.MAX_POINTS(MAXP), .FRAC_BITS(FRAC)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.knot(knot),
		.valid(valid),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && valid) sb.check_moment(result);
	end

	task automatic send_knot(input bit [15:0] x, input bit [31:0] f, input bit last);
		knot_t k;
		k.x_coord = x;
		k.f_value = f;
		k.last_point = last;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		knot = k;
		do @(posedge clk); while (busy);
		sb.note_knot(k);
		knots_sent++;
		@(negedge clk);
	endtask

	// one knot set; bad_order puts a repeated or falling x somewhere
	task automatic send_set(input int n, input bit bad_order);
		bit [15:0] xv[];
		int        gaps[];
		int        total;
		int        base;
		int        wide;
		int        fmode;
		int        bad;
		bit [31:0] f;
		xv = new[n];
		gaps = new[n];
		total = 0;
		wide = $urandom_range(3);
		fmode = $urandom_range(3);
		for (int i = 1; i < n; i++) begin
			gaps[i] = (wide == 0) ? $urandom_range(1, 65535 / n) : $urandom_range(1, 9);
			total += gaps[i];
		end
		base = $urandom_range(0, 65535 - total);
		xv[0] = base;
		for (int i = 1; i < n; i++) xv[i] = xv[i-1] + gaps[i];
		if (bad_order && n > 1) begin
			bad = $urandom_range(1, n - 1);
			xv[bad] = $urandom_range(1) ? xv[bad-1] : xv[bad-1] - $urandom_range(0, xv[bad-1]);
		end
		for (int i = 0; i < n; i++) begin
			case (fmode)
				0: f = $urandom;
				1: f = 32'($urandom_range(0, 2000)) - 32'd1000;
				default: f = {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
			endcase
			send_knot(xv[i], f, i == n - 1);
		end
	endtask

	initial begin
		#(12 * 4000000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int n;
		int limit;
		int phase_pcts[4] = '{0, 76, 0, 13};
		sb = new();
		idle_pct = 0;
		knots_sent = 0;
		start = 1'b0;
		knot = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single and two-knot sets solve to zeros
		send_knot(16'd5, 32'h7FFF_FFFF, 1'b1);
		send_knot(16'd0, 32'h8000_0000, 1'b0);
		send_knot(16'd1, 32'h7FFF_FFFF, 1'b1);
		// full x range
		send_knot(16'd0, 32'h0001_0000, 1'b0);
		send_knot(16'd32767, 32'hFFFF_0000, 1'b0);
		send_knot(16'hFFFF, 32'h0000_0000, 1'b1);
		// extreme values on unit gaps saturate
		send_knot(16'd100, 32'h7FFF_FFFF, 1'b0);
		send_knot(16'd101, 32'h8000_0000, 1'b0);
		send_knot(16'd102, 32'h7FFF_FFFF, 1'b0);
		send_knot(16'd103, 32'h8000_0000, 1'b0);
		send_knot(16'd104, 32'h7FFF_FFFF, 1'b1);
		// repeated x, then falling x
		send_knot(16'd10, 32'd1, 1'b0);
		send_knot(16'd10, 32'd2, 1'b0);
		send_knot(16'd20, 32'd3, 1'b1);
		send_knot(16'd50, 32'd1, 1'b0);
		send_knot(16'd60, 32'd9, 1'b0);
		send_knot(16'd40, 32'd2, 1'b0);
		send_knot(16'd70, 32'd3, 1'b1);
		// ordinary smooth set
		send_knot(16'd1, 32'h0000_4000, 1'b0);
		send_knot(16'd3, 32'h0002_0000, 1'b0);
		send_knot(16'd4, 32'hFFFE_8000, 1'b0);
		send_knot(16'd8, 32'h0000_0000, 1'b1);

		// over capacity, without order error
		send_set(MAXP + 2, 1'b0);
		knots_sent = 0;
		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pcts[p];
			while (knots_sent < 100 * (p + 1)) begin
				n = $urandom_range(99);
				if (n < 3) send_set($urandom_range(MAXP, MAXP + 3), $urandom_range(9) == 0);
				else if (n < 10) send_set($urandom_range(1, 2), 1'b0);
				else if (n < 20) send_set($urandom_range(3, 10), 1'b1);
				else if (n < 30) send_set($urandom_range(11, 30), 1'b0);
				else send_set($urandom_range(3, 10), 1'b0);
			end
			if (p == 1) begin
				start = 1'b0;
				while (sb.pending() != 0) @(negedge clk);
			end
		end
		start = 1'b0;

		limit = 0;
		while (sb.pending() != 0 && limit < 200000) begin
			@(posedge clk);
			limit++;
		end
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ natural_cubic_spline_moments_unit.f @@
hdl/ncsm_pkg.sv
hdl/ncsm_div.sv
hdl/natural_cubic_spline_moments_unit.sv
tb/sv/tb.sv
